// File: hw/rtl/brse_pkg.sv
package brse_pkg;

   localparam int unsigned WORD_W      = 32;
   localparam int unsigned CMD_W       = 3;
   localparam int unsigned ID_W        = 17;
   localparam int unsigned IDX_W       = 11;
   localparam int unsigned BIT_W       = 5;
   // word address field; the front end fills at most its low 12 bits
   localparam int unsigned ADDR_MAX_W  = 16;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef enum logic [CMD_W-1:0] {
      CMD_SET    = 3'd0,
      CMD_CLEAR  = 3'd1,
      CMD_TEST   = 3'd2,
      CMD_AND    = 3'd3,
      CMD_OR     = 3'd4,
      CMD_EXPAND = 3'd5
   } brse_cmd_type;

   // what the back end does with one queued item
   typedef enum logic [1:0] {
      OP_AND,
      OP_OR,
      OP_TEST,
      OP_EXPAND
   } brse_op_type;

   typedef struct packed {
      brse_op_type              op;
      logic [ADDR_MAX_W-1:0]    addr;
      logic [WORD_W-1:0]        operand;  // mask, operand word, or read mask
      logic [ID_W-1:0]          id;       // echoed id or expand base id
   } brse_entry_type;

   typedef struct packed {
      logic                     valid;
      brse_entry_type           entry;
   } brse_head_type;

   // index of the lowest set bit; zero for an empty word
   function automatic logic [BIT_W-1:0] lowest_bit_index(input logic [WORD_W-1:0] word);
      logic [WORD_W-1:0] low;
      logic [BIT_W-1:0]  idx;
      low = word & (~word + WORD_W'(1));
      idx = '0;
      for (int p = 0; p < WORD_W; p++) begin
         if (low[p]) begin
            idx = idx | BIT_W'(p);
         end
      end
      return idx;
   endfunction

endpackage

// File: hw/rtl/brse_if.sv
interface brse_req_if import brse_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [ID_W-1:0]   row_id;
   logic [IDX_W-1:0]  word_index;
   logic [WORD_W-1:0] word_value;

   modport source (output valid, output cmd, output row_id, output word_index,
                   output word_value, input ready);
   modport sink   (input valid, input cmd, input row_id, input word_index,
                   input word_value, output ready);
endinterface

interface brse_rsp_if import brse_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ID_W-1:0]   row_id_out;
   logic              found;
   logic              last;

   modport source (output valid, output row_id_out, output found, output last,
                   input ready);
   modport sink   (input valid, input row_id_out, input found, input last,
                   output ready);
endinterface

// File: hw/rtl/brse_ram.sv
module brse_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 2048
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/brse_front.sv
module brse_front import brse_pkg::*; #(
   parameter int unsigned WORDS = 2048
) (
   input  logic           clearing,
   input  logic           queue_full,
   brse_req_if.sink       req_chan,
   output logic           push,
   output brse_entry_type entry
);

   localparam logic [31:0] ID_LIMIT  = 32'(WORDS) * 32'd32;
   localparam logic [31:0] IDX_LIMIT = 32'(WORDS);

   logic [ID_W-1:0]   pos;
   logic              id_ok;
   logic              idx_ok;
   logic [WORD_W-1:0] id_mask;
   logic              keep;

   assign pos     = req_chan.row_id - ID_W'(1);
   assign id_ok   = (req_chan.row_id != '0) && ({15'd0, pos} < ID_LIMIT);
   assign idx_ok  = ({21'd0, req_chan.word_index} < IDX_LIMIT);
   assign id_mask = WORD_W'(1) << pos[BIT_W-1:0];

   always_comb begin
      keep          = 1'b1;
      entry.op      = OP_TEST;
      entry.addr    = ADDR_MAX_W'(pos[ID_W-1:BIT_W]);
      entry.operand = '0;
      entry.id      = req_chan.row_id;
      unique case (brse_cmd_type'(req_chan.cmd))
         CMD_SET: begin
            entry.op      = OP_OR;
            entry.operand = id_mask;
            keep          = id_ok;
         end
         CMD_CLEAR: begin
            entry.op      = OP_AND;
            entry.operand = ~id_mask;
            keep          = id_ok;
         end
         CMD_TEST: begin
            entry.op      = OP_TEST;
            entry.operand = id_ok ? id_mask : '0;
         end
         CMD_AND: begin
            entry.op      = OP_AND;
            entry.addr    = ADDR_MAX_W'(req_chan.word_index);
            entry.operand = req_chan.word_value;
            keep          = idx_ok;
         end
         CMD_OR: begin
            entry.op      = OP_OR;
            entry.addr    = ADDR_MAX_W'(req_chan.word_index);
            entry.operand = req_chan.word_value;
            keep          = idx_ok;
         end
         CMD_EXPAND: begin
            entry.op      = OP_EXPAND;
            entry.addr    = ADDR_MAX_W'(req_chan.word_index);
            entry.operand = idx_ok ? '1 : '0;
            entry.id      = ID_W'({req_chan.word_index, 5'd0}) + ID_W'(1);
         end
         default: begin
            keep = 1'b0;  // unused command codes vanish here
         end
      endcase
   end

   assign req_chan.ready = !clearing && !queue_full;
   assign push           = req_chan.valid && req_chan.ready && keep;

endmodule

// File: hw/rtl/brse_queue.sv
module brse_queue import brse_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  brse_entry_type push_entry,
   input  logic           pop,
   output logic           full,
   output brse_head_type  head
);

   brse_entry_type        slots_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;
   logic                  do_pop;

   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + (QUEUE_AW+1)'(1);
      end else if (do_pop && !push) begin
         count_in = count_ff - (QUEUE_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign full = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign head = {(count_ff != '0), slots_ff[rd_ptr_ff]};

endmodule

// File: hw/rtl/brse_back.sv
module brse_back import brse_pkg::*; #(
   parameter int unsigned WORDS = 2048
) (
   input  logic          clock,
   input  logic          reset,
   input  brse_head_type head,
   output logic          pop,
   output logic          clearing,
   brse_rsp_if.source    rsp_chan
);

   localparam int unsigned AW = (WORDS > 1) ? $clog2(WORDS) : 1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_EMIT
   } state_type;

   state_type         state_ff, state_in;
   brse_entry_type    cur_ff, cur_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic              found_ff, found_in;
   logic [AW-1:0]     clr_addr_ff, clr_addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]   rsp_id_ff, rsp_id_in;
   logic              rsp_found_ff, rsp_found_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              wr_en, rd_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [WORD_W-1:0] wr_data, rd_data;
   logic              out_free;
   logic [BIT_W-1:0]  low_idx;
   logic [WORD_W-1:0] rest;

   brse_ram #(
      .WIDTH (WORD_W),
      .DEPTH (WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign low_idx  = lowest_bit_index(word_ff);
   assign rest     = word_ff & (word_ff - WORD_W'(1));

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      word_in      = word_ff;
      found_in     = found_ff;
      clr_addr_in  = clr_addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_id_in    = rsp_id_ff;
      rsp_found_in = rsp_found_ff;
      rsp_last_in  = rsp_last_ff;
      wr_en        = 1'b0;
      wr_addr      = clr_addr_ff;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = AW'(head.entry.addr);
      pop          = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en       = 1'b1;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (head.valid) begin
               pop      = 1'b1;
               rd_en    = 1'b1;
               cur_in   = head.entry;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            wr_addr = AW'(cur_ff.addr);
            unique case (cur_ff.op)
               OP_AND: begin
                  wr_en    = 1'b1;
                  wr_data  = rd_data & cur_ff.operand;
                  state_in = ST_IDLE;
               end
               OP_OR: begin
                  wr_en    = 1'b1;
                  wr_data  = rd_data | cur_ff.operand;
                  state_in = ST_IDLE;
               end
               OP_TEST: begin
                  found_in = |(rd_data & cur_ff.operand);
                  state_in = ST_EMIT;
               end
               OP_EXPAND: begin
                  word_in  = rd_data & cur_ff.operand;
                  state_in = ST_EMIT;
               end
            endcase
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (cur_ff.op == OP_TEST) begin
                  rsp_id_in    = cur_ff.id;
                  rsp_found_in = found_ff;
                  rsp_last_in  = 1'b1;
                  state_in     = ST_IDLE;
               end else if (word_ff == '0) begin
                  // empty word reports one miss
                  rsp_id_in    = '0;
                  rsp_found_in = 1'b0;
                  rsp_last_in  = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  rsp_id_in    = cur_ff.id + ID_W'(low_idx);
                  rsp_found_in = 1'b1;
                  rsp_last_in  = (rest == '0);
                  word_in      = rest;
                  if (rest == '0) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff       <= cur_in;
      word_ff      <= word_in;
      found_ff     <= found_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_found_ff <= rsp_found_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign clearing            = (state_ff == ST_CLEAR);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.row_id_out = rsp_id_ff;
   assign rsp_chan.found      = rsp_found_ff;
   assign rsp_chan.last       = rsp_last_ff;

endmodule

// File: hw/rtl/bitmap_row_set_engine_core.sv
// bitmap of row ids, WORDS words of 32 bits, row id n lives at bit (n-1)%32
// of word (n-1)/32
// req channel: one item per command (set, clear, test, and word, or word,
//   expand word); set/clear/and/or give no result, test gives one result,
//   expand gives one result per set bit in ascending id order, last flagged,
//   or a single {0, found 0, last} item for an empty word
// rsp channel: row_id_out, found, last, held in an output register
// front end classifies the item and pushes it into a 4-deep queue; unused
//   command codes and out-of-range set/clear/and/or are dropped there
// back end pops one item, reads the store (registered read port), then writes
//   back or emits results; it works on one item at a time
// steps: and/or/set/clear go idle (pop, read) then exec (write back); test and
//   expand go on from exec to emit, where expand stays for each result
// the one-item-at-a-time read/modify/write holds the next item in the queue
// reset: the back end sweeps the store to zero, one word a cycle; req ready
//   stays low for that whole pass
// stall: a result waits in the output register while rsp ready is low; the
//   back end holds, and req keeps accepting until the queue fills
module bitmap_row_set_engine_core import brse_pkg::*; #(
   parameter int unsigned WORDS = 2048
) (
   input  logic       clock,
   input  logic       reset,
   brse_req_if.sink   req_chan,
   brse_rsp_if.source rsp_chan
);

   logic           clearing;
   logic           queue_full;
   logic           push;
   logic           pop;
   brse_entry_type push_entry;
   brse_head_type  head;

   // decode and classify the incoming command
   brse_front #(
      .WORDS (WORDS)
   ) u_front (
      .clearing   (clearing),
      .queue_full (queue_full),
      .req_chan   (req_chan),
      .push       (push),
      .entry      (push_entry)
   );

   // decouples the request side from the store access
   brse_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .head       (head)
   );

   // store access, result generation and the reset sweep
   brse_back #(
      .WORDS (WORDS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .clearing (clearing),
      .rsp_chan (rsp_chan)
   );

endmodule

// File: hw/rtl/brse_checker.sv
module brse_checker import brse_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input logic [ID_W-1:0] rsp_row_id_out,
   input logic            rsp_found,
   input logic            rsp_last
);

   // nothing goes in or out while the store is being swept
   assert property (@(posedge clock) reset |=> !req_ready && !rsp_valid)
      else $error("activity right after reset");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_row_id_out)
         && $stable(rsp_found) && $stable(rsp_last))
      else $error("stalled result changed");

   // a miss is always the only result of its item
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_last)
      else $error("miss without last");

   // a hit always names a real row id
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_row_id_out != '0)
      else $error("hit with row id zero");

endmodule

bind bitmap_row_set_engine_core brse_checker u_brse_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_row_id_out (rsp_chan.row_id_out),
   .rsp_found      (rsp_chan.found),
   .rsp_last       (rsp_chan.last)
);
